// ===== rtl/service_registry_table_top_defines.svh =====
// Assertion macros shared by the registry RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef SERVICE_REGISTRY_TABLE_TOP_DEFINES_SVH
`define SERVICE_REGISTRY_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds on every edge outside reset.
`define SRT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("registry check failed");
// Antecedent on one edge implies consequent on the next.
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("registry check failed");
`else
`define SRT_ASSERT(label, prop)
`define SRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/srt_pkg.sv =====
// Types and constants for the service registry table.
// No dependencies; imported by every registry module.
package srt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_W            = 32;
    localparam int FUNC_W          = 8;

    localparam logic [FUNC_W-1:0] FUNC_REGISTER = 8'h01;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 8'h02;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   sender_id;
        logic [ID_W-1:0]   service_key;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0] reply_target;
        logic [ID_W-1:0] provider_id;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] provider;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic scan_en;
        logic load_rsp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic done;
        logic rsp_free;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

endpackage

// ===== rtl/srt_ctrl.sv =====
// Registry controller: accepts items, sequences the lookup scan, hands off replies.
// Depends on srt_pkg; drives commands to srt_dpath and reads its status.
module srt_ctrl
    import srt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.load_rsp = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_lookup)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // stop issuing reads once the outcome is known
                cmd.scan_en = !status.done;
                if (status.done)
                begin
                    if (status.rsp_free)
                    begin
                        cmd.load_rsp = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (status.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/srt_dpath.sv =====
// Registry datapath: slot memory, fill count, scan pipeline and reply register.
// Depends on srt_pkg and the assertion macros; commanded by srt_ctrl.
`include "service_registry_table_top_defines.svh"

module srt_dpath
    import srt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  req_t       req,
    output rsp_t       rsp,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    slot_t slot_mem [TABLE_DEPTH];

    // slots fill in order and are never freed: the count marks the valid ones
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic [CW-1:0]   idx_reg;
    logic [CW-1:0]   idx_next;
    logic            pend_reg;
    logic            pend_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    slot_t           rd_data_reg;
    rsp_t            rsp_reg;
    logic [ID_W-1:0] key_reg;
    logic [ID_W-1:0] sender_reg;

    logic wr_en;
    logic issue;
    logic hit;

    assign wr_en = cmd.accept && (req.func == FUNC_REGISTER) && (fill_reg < DEPTH_C);
    assign issue = cmd.scan_en && (idx_reg < fill_reg);
    assign hit   = pend_reg && (rd_data_reg.key == key_reg);

    assign status.is_lookup = (req.func == FUNC_LOOKUP);
    assign status.done      = hit || (!pend_reg && !(idx_reg < fill_reg));
    assign status.rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en)
        begin
            fill_next = CW'(fill_reg + 1'b1);
        end
    end

    always_comb
    begin
        idx_next  = idx_reg;
        pend_next = pend_reg;
        priority if (cmd.accept)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
        end
        else if (cmd.scan_en)
        begin
            pend_next = issue;
            if (issue)
            begin
                idx_next = CW'(idx_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[fill_reg[AW-1:0]] <= '{key: req.service_key, provider: req.sender_id};
        end
        if (issue)
        begin
            rd_data_reg <= slot_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg    <= req.service_key;
            sender_reg <= req.sender_id;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.reply_target <= sender_reg;
            rsp_reg.provider_id  <= hit ? rd_data_reg.provider : '0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `SRT_ASSERT(a_fill_bound, fill_reg <= DEPTH_C)
    `SRT_ASSERT(a_idx_within_fill, idx_reg <= fill_reg)
    `SRT_ASSERT_NEXT(a_fill_advance, wr_en, fill_reg == CW'($past(fill_reg) + 1'b1))
    `SRT_ASSERT_NEXT(a_scan_hold, !cmd.accept && !cmd.scan_en, $stable(pend_reg) && $stable(idx_reg))

endmodule

// ===== rtl/service_registry_table_top.sv =====
// Top level of the service registry table: controller plus datapath.
// Depends on srt_pkg, srt_ctrl and srt_dpath.
//
//   channel | handshake            | payload     | dir
//   --------+----------------------+-------------+-----
//   req     | req_valid, req_stall | req_t item  | in
//   rsp     | rsp_valid, rsp_stall | rsp_t item  | out
//
// Register and ignored items do not stall the input; the next item is accepted right after.
// A lookup scans the filled slots through the single memory read port, one slot per
// cycle with a registered read, and stops at the lowest matching slot or the last filled one.
// Reset clears the fill count and the control state, not the slot memory, which needs no clearing pass.
// A reply waiting on rsp_stall holds in the output register; a finished lookup waits
// for it in ST_HOLD, which stalls the input; until then register items keep flowing.
module service_registry_table_top
    import srt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    srt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    srt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for service_registry_table_top: register, lookup and ignored items.
// Needs srt_pkg and the registry RTL. A scoreboard class keeps its own copy of the table
// and predicts each reply.
module tb_top;
    import srt_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int QUIET_ITEMS    = 150;
    localparam int PRESSURE_ITEM  = 400;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    class registry_scoreboard;
        bit          slot_used  [DEPTH];
        logic [31:0] slot_key   [DEPTH];
        logic [31:0] slot_owner [DEPTH];
        int          fill;
        rsp_t        predicted_replies[$];
        int          mismatches;
        int          replies_checked;
        int          lookups;
        int          hits;
        int          registers;
        int          drops;
        int          ignored;

        function new();
            fill = 0;
            mismatches = 0;
            replies_checked = 0;
            lookups = 0;
            hits = 0;
            registers = 0;
            drops = 0;
            ignored = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void note_message(req_t m);
            bit          found;
            logic [31:0] owner;
            rsp_t        reply;
            found = 1'b0;
            owner = '0;
            case (m.func)
                FUNC_REGISTER:
                begin
                    registers++;
                    // take the lowest free slot
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!found && !slot_used[i])
                        begin
                            slot_used[i]  = 1'b1;
                            slot_key[i]   = m.service_key;
                            slot_owner[i] = m.sender_id;
                            found = 1'b1;
                            fill++;
                        end
                    end
                    if (!found)
                        drops++;
                end
                FUNC_LOOKUP:
                begin
                    lookups++;
                    // lowest matching slot wins among duplicates
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!found && slot_used[i] && slot_key[i] == m.service_key)
                        begin
                            owner = slot_owner[i];
                            found = 1'b1;
                        end
                    end
                    if (found)
                        hits++;
                    reply.reply_target = m.sender_id;
                    reply.provider_id  = owner;
                    predicted_replies.push_back(reply);
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_reply(rsp_t got);
            rsp_t want;
            if (predicted_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: reply target=%h provider=%h with no lookup pending",
                             got.reply_target, got.provider_id);
                return;
            end
            want = predicted_replies.pop_front();
            replies_checked++;
            if (got.reply_target !== want.reply_target || got.provider_id !== want.provider_id)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: reply %0d: target exp %h got %h, provider exp %h got %h",
                             replies_checked, want.reply_target, got.reply_target,
                             want.provider_id, got.provider_id);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    registry_scoreboard ledger;
    bit quiet;
    bit long_hold_req;
    int idle_cycles;
    int input_stall_cycles;

    service_registry_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] random_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 32'h0000_0100 + $urandom_range(0, 5);
        else if (r == 4)
            return 32'h0000_0000;
        else if (r == 5)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    function automatic req_t random_message();
        req_t m;
        int   pick;
        pick = $urandom_range(0, 99);
        m.sender_id   = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom;
        m.service_key = random_key();
        if (pick < 18)
            m.func = FUNC_REGISTER;
        else if (pick < 88)
        begin
            m.func = FUNC_LOOKUP;
            // aim most lookups at keys already in the table
            if (ledger.fill > 0 && $urandom_range(0, 9) < 6)
                m.service_key = ledger.slot_key[$urandom_range(0, ledger.fill - 1)];
        end
        else
        begin
            do
                m.func = FUNC_W'($urandom_range(0, 255));
            while (m.func == FUNC_REGISTER || m.func == FUNC_LOOKUP);
        end
        return m;
    endfunction

    function automatic req_t make_message(logic [FUNC_W-1:0] func, logic [31:0] sender,
                                          logic [31:0] key);
        req_t m;
        m.func        = func;
        m.sender_id   = sender;
        m.service_key = key;
        return m;
    endfunction

    task automatic send_message(input req_t m);
        req       <= m;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        ledger.note_message(m);
    endtask

    task automatic sender_pause(input int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // reply side: random hold-offs, one long hold on request, none once quiet
    initial
    begin
        rsp_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            ledger.check_reply(rsp);
    end

    // end the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_stall)
            input_stall_cycles++;
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("service_registry_table_top verification failed");
            $finish;
        end
    end

    initial
    begin
        req_t m;
        int   counted;
        ledger = new();
        quiet = 1'b0;
        long_hold_req = 1'b0;
        idle_cycles = 0;
        input_stall_cycles = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, unknown types, zero provider, duplicates, extremes
        send_message(make_message(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000));
        send_message(make_message(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
        send_message(make_message(8'h00, 32'h1111_1111, 32'h0000_0055));
        send_message(make_message(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_message(make_message(8'h03, 32'h2222_2222, 32'h0000_0055));
        send_message(make_message(8'h81, 32'h3333_3333, 32'h0000_0055));
        send_message(make_message(FUNC_REGISTER, 32'h0000_0000, 32'h0000_0000));
        send_message(make_message(FUNC_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sender_pause(3);
        send_message(make_message(FUNC_REGISTER, 32'hA5A5_A5A5, 32'h0000_1234));
        send_message(make_message(FUNC_REGISTER, 32'h5A5A_5A5A, 32'h0000_1234));
        send_message(make_message(FUNC_LOOKUP, 32'h0000_0007, 32'h0000_0000));
        send_message(make_message(FUNC_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF));
        send_message(make_message(FUNC_LOOKUP, 32'h0000_0001, 32'h0000_1234));
        send_message(make_message(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'hDEAD_BEEF));
        send_message(make_message(8'h41, 32'h4444_4444, 32'h0000_0055));
        send_message(make_message(8'h80, 32'h6666_6666, 32'h0000_0055));
        send_message(make_message(FUNC_LOOKUP, 32'h5555_5555, 32'h0000_0055));
        send_message(make_message(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted == PRESSURE_ITEM)
                long_hold_req = 1'b1;
            quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
            if (!quiet && !long_hold_req && $urandom_range(0, 4) == 0)
                sender_pause($urandom_range(1, 14));
            m = random_message();
            send_message(m);
            counted++;
        end
        req_valid <= 1'b0;

        while (ledger.predicted_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lookups (%0d hits), %0d registers (%0d dropped on a full table),",
                 ledger.lookups, ledger.hits, ledger.registers, ledger.drops);
        $display("%0d ignored types, %0d replies checked, input held back %0d cycles.",
                 ledger.ignored, ledger.replies_checked, input_stall_cycles);
        if (ledger.predicted_replies.size() != 0)
            $display("ERROR: %0d predicted replies never arrived", ledger.predicted_replies.size());
        if (ledger.mismatches == 0 && ledger.predicted_replies.size() == 0)
            $display("service_registry_table_top verification clean");
        else
            $display("service_registry_table_top verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_ctrl.sv
rtl/srt_dpath.sv
rtl/service_registry_table_top.sv
tb/tb_top.sv
